/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the json string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // request: one source byte of a string body
  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_end;
  } jsu_req_t;

  // response: one decoded result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       hex_error;
    logic       run_last;
  } jsu_rsp_t;

  // work handed from front to back: up to three output bytes
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            byte_valid;
    logic            hex_error;
    logic            string_end;
  } jsu_job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } jsu_qstat_t;

  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [2:0]  HexLen            = 3'd4;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;

  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [5:0] Utf8Mask  = 6'h3F;
  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;

endpackage

/* hdl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Accepts source bytes, tracks escape state and builds output jobs.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  jsu_pkg::jsu_req_t   req,
  input  jsu_pkg::jsu_qstat_t qstat,
  output logic                push,
  output jsu_pkg::jsu_job_t   job
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  mode_t      scan_mode, scan_mode_next;
  logic [2:0] hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic [2:0] hex_digits_seen, hex_digits_seen_next;
  logic       hex_prefix_open, hex_prefix_open_next;

  logic       accept;
  logic       produce;
  logic [4:0] digit;

  // hex digit value, bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h37);
    return d;
  endfunction

  // utf-8 encoding of a collected code point, or the error item
  function automatic jsu_job_t finish_hex(input logic [15:0] cp, input logic have);
    jsu_job_t j;
    j = '0;
    if (!have) begin
      j.hex_error = 1'b1;
    end else if (cp < Utf8Lim1) begin
      j.byte_valid = 1'b1;
      j.bytes[0]   = cp[7:0];
    end else if (cp < Utf8Lim2) begin
      j.byte_valid = 1'b1;
      j.bytes[0]   = Utf8Lead2 | {3'b000, cp[10:6]};
      j.bytes[1]   = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
      j.last_idx   = 2'd1;
    end else begin
      j.byte_valid = 1'b1;
      j.bytes[0]   = Utf8Lead3 | {4'b0000, cp[15:12]};
      j.bytes[1]   = Utf8Cont | {2'b00, cp[11:6]};
      j.bytes[2]   = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
      j.last_idx   = 2'd2;
    end
    return j;
  endfunction

  assign req_ready = !qstat.full;
  assign accept    = req_valid && req_ready;
  assign push      = accept && produce;
  assign digit     = hex_digit(req.in_byte);

  // classify the byte and work out the next scan state
  always_comb begin
    scan_mode_next       = scan_mode;
    hex_count_next       = hex_count;
    hex_value_next       = hex_value;
    hex_digits_seen_next = hex_digits_seen;
    hex_prefix_open_next = hex_prefix_open;
    produce              = 1'b0;
    job                  = '0;
    if (req.source_end) begin
      if (scan_mode == MODE_HEX) begin
        job = finish_hex(hex_value, hex_digits_seen != 3'd0);
      end
      job.string_end       = 1'b1;
      produce              = 1'b1;
      scan_mode_next       = MODE_NORMAL;
      hex_count_next       = '0;
      hex_value_next       = '0;
      hex_digits_seen_next = '0;
      hex_prefix_open_next = 1'b1;
    end else begin
      case (scan_mode)
        MODE_ESCAPE: begin
          if (req.in_byte == ChU) begin
            scan_mode_next       = MODE_HEX;
            hex_count_next       = '0;
            hex_value_next       = '0;
            hex_digits_seen_next = '0;
            hex_prefix_open_next = 1'b1;
          end else begin
            job.byte_valid = 1'b1;
            case (req.in_byte)
              ChB:     job.bytes[0] = 8'h08;
              ChF:     job.bytes[0] = 8'h0C;
              ChN:     job.bytes[0] = 8'h0A;
              ChR:     job.bytes[0] = 8'h0D;
              ChT:     job.bytes[0] = 8'h09;
              default: job.bytes[0] = req.in_byte;
            endcase
            produce        = 1'b1;
            scan_mode_next = MODE_NORMAL;
          end
        end
        MODE_HEX: begin
          if (hex_prefix_open && !digit[4]) begin
            hex_value_next       = {hex_value[11:0], digit[3:0]};
            hex_digits_seen_next = hex_digits_seen + 3'd1;
          end else begin
            hex_prefix_open_next = 1'b0;
          end
          hex_count_next = hex_count + 3'd1;
          if (hex_count_next >= HexLen) begin
            job                  = finish_hex(hex_value_next, hex_digits_seen_next != 3'd0);
            produce              = 1'b1;
            scan_mode_next       = MODE_NORMAL;
            hex_count_next       = '0;
            hex_value_next       = '0;
            hex_digits_seen_next = '0;
            hex_prefix_open_next = 1'b1;
          end
        end
        default: begin
          if (req.in_byte == ChQuote) begin
            job.string_end       = 1'b1;
            produce              = 1'b1;
            scan_mode_next       = MODE_NORMAL;
            hex_count_next       = '0;
            hex_value_next       = '0;
            hex_digits_seen_next = '0;
            hex_prefix_open_next = 1'b1;
          end else if (req.in_byte == ChBackslash) begin
            scan_mode_next = MODE_ESCAPE;
          end else begin
            job.byte_valid = 1'b1;
            job.bytes[0]   = req.in_byte;
            produce        = 1'b1;
            scan_mode_next = MODE_NORMAL;
          end
        end
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_NORMAL;
      hex_count       <= '0;
      hex_value       <= '0;
      hex_digits_seen <= '0;
      hex_prefix_open <= 1'b1;
    end else if (accept) begin
      scan_mode       <= scan_mode_next;
      hex_count       <= hex_count_next;
      hex_value       <= hex_value_next;
      hex_digits_seen <= hex_digits_seen_next;
      hex_prefix_open <= hex_prefix_open_next;
    end
  end

endmodule

/* hdl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_job_t   push_job,
  input  logic                pop,
  output jsu_pkg::jsu_job_t   head,
  output jsu_pkg::jsu_qstat_t qstat
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

/* hdl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head job byte by byte and drives the response channel.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::jsu_job_t   head,
  input  jsu_pkg::jsu_qstat_t qstat,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output jsu_pkg::jsu_rsp_t   rsp
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       last;
  logic       sent;

  assign rsp_valid = !qstat.empty;
  assign last      = (idx == head.last_idx);
  assign sent      = rsp_valid && rsp_ready;
  assign pop       = sent && last;

  // response fields from the current byte of the head job
  always_comb begin
    rsp.out_byte   = head.bytes[idx];
    rsp.byte_valid = head.byte_valid;
    rsp.hex_error  = head.hex_error;
    rsp.string_end = head.string_end && last;
    rsp.run_last   = last;
  end

  // byte index within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (sent) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* hdl/json_string_unescape_core.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_core
// JSON string body unescaper with UTF-8 output of \u escapes.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req) takes one source byte of a string
// body per cycle, or a source_end marker. Response channel
// (rsp_valid/rsp_ready/rsp) gives the decoded result items in order; the last
// item caused by a request carries run_last.
// A request that causes results has them queued as one job; the back part
// sends one result per cycle while rsp_ready is high. Results are registered
// in the job queue and are offered from its head, behind any older jobs.
// Requests are taken one per cycle while the job queue (QUEUE_DEPTH jobs)
// has room; a backslash and the first bytes of a \u escape make no job.
// Sustained rate: one request per cycle, bounded by the response side at one
// result per cycle when \u escapes expand to two or three bytes.
// When the receiver stalls, the queue fills and req_ready drops once it is
// full; no result is lost.
// Synchronous reset clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
module json_string_unescape_core #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  jsu_pkg::jsu_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output jsu_pkg::jsu_rsp_t rsp
);
  import jsu_pkg::*;

  jsu_qstat_t qstat;
  jsu_job_t   push_job;
  jsu_job_t   head;
  logic       push;
  logic       pop;

  // classify and build jobs
  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .job       (push_job)
  );

  // job queue
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // serialize results
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
